### src/bad_pkg.sv
// shared types and constants for the block average downscaler
// no dependencies
`default_nettype none
package bad_pkg;
  localparam int unsigned MaxColsDefault   = 4096;
  localparam int unsigned MaxFactorDefault = 512;
  localparam int unsigned RowLimit         = 4096;
  localparam int unsigned SumW             = 26;

  localparam logic [1:0] RegScale = 2'd0;
  localparam logic [1:0] RegCols  = 2'd1;
  localparam logic [1:0] RegRows  = 2'd2;

  typedef struct packed {
    logic [7:0] pixel_in;
    logic       frame_start;
  } in_req_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       row_end;
    logic       frame_end;
  } out_req_t;

  // command from controller to datapath
  typedef struct packed {
    logic load;     // latch pixel and position info
    logic finish;   // add stored sum, write back
    logic div_go;   // start divider
  } bad_cmd_t;

  typedef struct packed {
    logic div_done;
    logic need_out;
    logic at_block_end;
    logic geo_busy;   // block grid being divided out
  } bad_sts_t;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StRead = 5'b00010,
    StSum  = 5'b00100,
    StDiv  = 5'b01000,
    StOut  = 5'b10000
  } bad_state_e;
endpackage
`default_nettype wire

### src/block_average_downscale.sv
// top level of the block average downscaler with apb register port
// depends on bad_pkg, bad_ctrl, bad_dp, bad_ram
// a request that completes its block passes through line store read, sum and
//   write back, a 26-step rounding divider and output before its result leaves
// requests are taken one at a time: input stalls until the last one is done and its
//   result, if any, has left, which output stalls can delay
// input stalls after reset and after each change of the clamped settings (grid divide)
// reset: counters, sums and state clear at once; registers return to 2, 512, 512
`default_nettype none
module block_average_downscale #(
  parameter int unsigned MaxCols   = bad_pkg::MaxColsDefault,
  parameter int unsigned MaxFactor = bad_pkg::MaxFactorDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire bad_pkg::in_req_t  in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output bad_pkg::out_req_t      out_req_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import bad_pkg::*;

  // configuration registers
  logic [9:0]  scale_q;
  logic [12:0] cols_q, rows_q;
  logic        wr;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= 10'd2;
      cols_q  <= 13'd512;
      rows_q  <= 13'd512;
    end else if (wr) begin
      unique case (paddr[3:2])
        RegScale: scale_q <= pwdata[9:0];
        RegCols:  cols_q  <= pwdata[12:0];
        RegRows:  rows_q  <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[3:2])
      RegScale: prdata = {22'd0, scale_q};
      RegCols:  prdata = {19'd0, cols_q};
      RegRows:  prdata = {19'd0, rows_q};
      default:  prdata = '0;
    endcase
  end

  bad_cmd_t cmd;
  bad_sts_t sts;

  // sequencer: one request at a time
  bad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // counters, block grid, line store and divider
  bad_dp #(.MaxCols(MaxCols), .MaxFactor(MaxFactor)) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .scale_i  (scale_q),
    .cols_i   (cols_q),
    .rows_i   (rows_q),
    .in_req_i (in_req_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .out_req_o(out_req_o)
  );

`ifndef SYNTHESIS
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("accepting while result waits");
  a_out_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o)) else $error("result without request");
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");
`endif
endmodule
`default_nettype wire

### src/bad_ram.sv
// generic simple dual port ram (one write, one read port) with registered read
// no dependencies
`default_nettype none
module bad_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### src/bad_ctrl.sv
// controller state machine for one pixel request at a time
// depends on bad_pkg
`default_nettype none
module bad_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output bad_pkg::bad_cmd_t    cmd_o,
  input  wire bad_pkg::bad_sts_t sts_i
);
  import bad_pkg::*;
  bad_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && !sts_i.geo_busy) begin
          cmd_o.load = 1'b1;
          state_d = StRead;
        end
      end
      StRead: begin
        if (sts_i.at_block_end) begin
          state_d = StSum;
        end else begin
          state_d = StIdle;
        end
      end
      StSum: begin
        cmd_o.finish = 1'b1;
        if (sts_i.need_out) begin
          cmd_o.div_go = 1'b1;
          state_d = StDiv;
        end else begin
          state_d = StIdle;
        end
      end
      StDiv: begin
        if (sts_i.div_done) state_d = StOut;
      end
      StOut: begin
        if (!out_stall_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_stall_o  = (state_q != StIdle) || sts_i.geo_busy;
  assign out_valid_o = (state_q == StOut);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("request taken while result pending");
`endif
endmodule
`default_nettype wire

### src/bad_dp.sv
// datapath: position counters, block grid, line store, rounding divider
// depends on bad_pkg and bad_ram
`default_nettype none
module bad_dp #(
  parameter int unsigned MaxCols   = bad_pkg::MaxColsDefault,
  parameter int unsigned MaxFactor = bad_pkg::MaxFactorDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [9:0]        scale_i,
  input  wire logic [12:0]       cols_i,
  input  wire logic [12:0]       rows_i,
  input  wire bad_pkg::in_req_t  in_req_i,
  input  wire bad_pkg::bad_cmd_t cmd_i,
  output bad_pkg::bad_sts_t      sts_o,
  output bad_pkg::out_req_t      out_req_o
);
  import bad_pkg::*;
  localparam int unsigned AW = $clog2(MaxCols);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned RW = 13;
  localparam int unsigned GW = (CW > RW) ? CW : RW;
  localparam int unsigned QW = 8;
  localparam int unsigned DW = 19; // f*f up to 2^18

  // clamped configuration
  logic [9:0]  f;
  logic [CW-1:0] cols;
  logic [12:0] rows;
  always_comb begin
    f = (scale_i == '0) ? 10'd1 :
        (32'(scale_i) > MaxFactor) ? 10'(MaxFactor) : scale_i;
    cols = (cols_i == '0) ? CW'(1) :
           (32'(cols_i) > MaxCols) ? CW'(MaxCols) : CW'(cols_i);
    rows = (rows_i == '0) ? 13'd1 :
           (32'(rows_i) > RowLimit) ? 13'(RowLimit) : rows_i;
  end

  // block grid: whole blocks per row and per column, divided out serially
  // after reset and after every change of the clamped settings
  logic [9:0]    f_seen_q;
  logic [CW-1:0] cols_seen_q;
  logic [12:0]   rows_seen_q;
  logic [GW-1:0] cq_q, rq_q;
  logic [9:0]    crem_q, rrem_q;
  logic [4:0]    gcnt_q;
  logic [10:0]   crem_sh, rrem_sh;
  logic          geo_dirty;
  logic [CW-1:0] ocols, wcols;
  logic [12:0]   orows, wrows;

  assign geo_dirty = (f != f_seen_q) || (cols != cols_seen_q) || (rows != rows_seen_q);
  assign crem_sh   = {crem_q, cq_q[GW-1]};
  assign rrem_sh   = {rrem_q, rq_q[GW-1]};
  assign ocols     = cq_q[CW-1:0];
  assign orows     = rq_q[12:0];
  // covered width and height; both stay within the frame size
  assign wcols     = ocols * CW'(f);
  assign wrows     = orows * 13'(f);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_seen_q <= '0; cols_seen_q <= '0; rows_seen_q <= '0;
      cq_q <= '0; rq_q <= '0; crem_q <= '0; rrem_q <= '0; gcnt_q <= '0;
    end else if (gcnt_q != 5'd0) begin
      if (crem_sh >= {1'b0, f_seen_q}) begin
        crem_q <= 10'(crem_sh - {1'b0, f_seen_q});
        cq_q   <= {cq_q[GW-2:0], 1'b1};
      end else begin
        crem_q <= crem_sh[9:0];
        cq_q   <= {cq_q[GW-2:0], 1'b0};
      end
      if (rrem_sh >= {1'b0, f_seen_q}) begin
        rrem_q <= 10'(rrem_sh - {1'b0, f_seen_q});
        rq_q   <= {rq_q[GW-2:0], 1'b1};
      end else begin
        rrem_q <= rrem_sh[9:0];
        rq_q   <= {rq_q[GW-2:0], 1'b0};
      end
      gcnt_q <= gcnt_q - 5'd1;
    end else if (geo_dirty) begin
      f_seen_q <= f; cols_seen_q <= cols; rows_seen_q <= rows;
      cq_q <= GW'(cols); rq_q <= GW'(rows);
      crem_q <= '0; rrem_q <= '0;
      gcnt_q <= 5'(GW);
    end
  end

  // counters
  logic [CW-1:0] icol_q, icol_d;
  logic [12:0]   irow_q, irow_d;
  logic [9:0]    cib_q, cib_d, rib_q, rib_d;
  logic [CW-1:0] ocol_q, ocol_d;
  logic [SumW-1:0] rsum_q, rsum_d;
  logic [SumW-1:0] tot_q, tot_d;
  logic [CW-1:0] oc_q, oc_d;
  logic rend_q, rend_d, fend_q, fend_d, first_row_q, first_row_d;
  logic need_q, need_d, blk_q, blk_d;

  // with frame_start applied
  logic [CW-1:0] icol, ocol;
  logic [12:0]   irow;
  logic [9:0]    cib, rib;
  logic [SumW-1:0] rsum;
  logic [SumW-1:0] s;
  logic blk_end, col_ok, row_ok, row_last, frame_last;

  always_comb begin
    if (in_req_i.frame_start) begin
      icol = '0; irow = '0; cib = '0; rib = '0; ocol = '0; rsum = '0;
    end else begin
      icol = icol_q; irow = irow_q; cib = cib_q; rib = rib_q; ocol = ocol_q;
      rsum = rsum_q;
    end
  end

  assign s          = rsum + SumW'(in_req_i.pixel_in);
  assign blk_end    = (cib + 10'd1 >= f);
  assign col_ok     = icol < wcols;
  assign row_ok     = irow < wrows;
  assign row_last   = (CW+1)'(ocol) + (CW+1)'(1) >= (CW+1)'(ocols);
  assign frame_last = 14'(irow) + 14'd1 >= 14'(wrows);

  always_comb begin
    icol_d = icol_q; irow_d = irow_q; cib_d = cib_q; rib_d = rib_q;
    ocol_d = ocol_q; rsum_d = rsum_q; tot_d = tot_q; oc_d = oc_q;
    rend_d = rend_q; fend_d = fend_q; first_row_d = first_row_q;
    need_d = need_q; blk_d = blk_q;
    if (cmd_i.load) begin
      blk_d = 1'b0;
      icol_d = icol; irow_d = irow; cib_d = cib; rib_d = rib;
      ocol_d = ocol; rsum_d = rsum;
      if (col_ok && row_ok) begin
        if (blk_end) begin
          rsum_d = '0; cib_d = '0;
          tot_d = s; oc_d = ocol;
          first_row_d = (rib == '0);
          need_d = (rib + 10'd1 >= f);
          rend_d = row_last;
          fend_d = row_last && frame_last;
          blk_d = 1'b1;
          ocol_d = ocol + CW'(1);
        end else begin
          rsum_d = s; cib_d = cib + 10'd1;
        end
      end
      if (icol + CW'(1) >= cols) begin
        icol_d = '0; cib_d = '0; rsum_d = '0; ocol_d = '0;
        if (irow + 13'd1 >= rows) begin
          irow_d = '0; rib_d = '0;
        end else begin
          irow_d = irow + 13'd1;
          rib_d = (rib + 10'd1 >= f) ? '0 : rib + 10'd1;
        end
      end else begin
        icol_d = icol + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      icol_q <= '0; irow_q <= '0; cib_q <= '0; rib_q <= '0; ocol_q <= '0;
      rsum_q <= '0; tot_q <= '0; oc_q <= '0; rend_q <= 1'b0; fend_q <= 1'b0;
      first_row_q <= 1'b0; need_q <= 1'b0; blk_q <= 1'b0;
    end else begin
      icol_q <= icol_d; irow_q <= irow_d; cib_q <= cib_d; rib_q <= rib_d;
      ocol_q <= ocol_d; rsum_q <= rsum_d; tot_q <= tot_d; oc_q <= oc_d;
      rend_q <= rend_d; fend_q <= fend_d; first_row_q <= first_row_d;
      need_q <= need_d; blk_q <= blk_d;
    end
  end

  // line store
  logic [SumW-1:0] rd_data;
  logic            we;
  bad_ram #(.Width(SumW), .Depth(MaxCols)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(oc_q[AW-1:0]),
    .wdata_i(tot_q + (first_row_q ? '0 : rd_data)),
    .raddr_i(oc_q[AW-1:0]),
    .rdata_o(rd_data)
  );
  assign we = cmd_i.finish && !oc_q[CW-1];

  // divider state: restoring, one quotient bit per cycle
  logic [SumW-1:0] num_q;
  logic [DW-1:0]   den_q;
  logic [DW:0]     rem_q;
  logic [QW-1:0]   quo_q;
  logic [4:0]      dcnt_q;
  logic            dbusy_q;
  logic [SumW:0]   total_full;
  logic [DW-1:0]   f2;
  logic [DW:0]     rem_sh;
  logic [SumW-1:0] num_sh;
  assign f2 = DW'(f) * DW'(f);
  assign total_full = {1'b0, tot_q + (first_row_q ? '0 : rd_data)};

  always_comb begin
    rem_sh = {rem_q[DW-1:0], num_q[SumW-1]};
    num_sh = {num_q[SumW-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= '0; den_q <= '0; rem_q <= '0; quo_q <= '0;
      dcnt_q <= '0; dbusy_q <= 1'b0;
    end else begin
      if (cmd_i.div_go) begin
        num_q <= total_full[SumW-1:0] + SumW'(f2 >> 1);
        den_q <= f2; rem_q <= '0; quo_q <= '0;
        dcnt_q <= 5'(SumW); dbusy_q <= 1'b1;
      end else if (dbusy_q) begin
        num_q <= num_sh;
        if (rem_sh >= {1'b0, den_q}) begin
          rem_q <= rem_sh - {1'b0, den_q};
          quo_q <= (quo_q[QW-1] ? quo_q : {quo_q[QW-2:0], 1'b1}) |
                   {QW{quo_q[QW-1]}};
        end else begin
          rem_q <= rem_sh;
          quo_q <= quo_q[QW-1] ? {QW{1'b1}} : {quo_q[QW-2:0], 1'b0};
        end
        dcnt_q <= dcnt_q - 5'd1;
        if (dcnt_q == 5'd1) dbusy_q <= 1'b0;
      end
    end
  end

  assign sts_o.div_done     = dbusy_q && (dcnt_q == 5'd1);
  assign sts_o.need_out     = need_q;
  assign sts_o.at_block_end = blk_q;
  assign sts_o.geo_busy     = geo_dirty || (gcnt_q != 5'd0);
  assign out_req_o.pixel_out = quo_q;
  assign out_req_o.row_end   = rend_q;
  assign out_req_o.frame_end = fend_q;

`ifndef SYNTHESIS
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_go |=> dbusy_q) else $error("divider did not start");
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dbusy_q |-> !cmd_i.load) else $error("load during divide");
  a_write_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> blk_q == 1'b0 || !cmd_i.load) else $error("write overlaps load");
  a_no_load_geo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> !sts_o.geo_busy) else $error("load while grid pending");
`endif
endmodule
`default_nettype wire
